>>> rtl/ldm_pkg.sv
`timescale 1ns / 1ps
// Package for the lens distortion map generator.
// Holds field widths, register indexes and fixed-point helper functions.
package ldm_pkg;

    localparam int FOCAL_BITS = 24;
    localparam int COEF_BITS  = 32;
    localparam int MAP_BITS   = 24;
    localparam int IDX_BITS   = 3;
    localparam int Q_FRAC     = 28;
    localparam int DIV_BITS   = 33;

    localparam int COORD_BITS_DEF = 12;
    localparam logic signed [31:0] RADIAL_K3_DEF = 32'sd0;

    typedef enum logic [IDX_BITS-1:0] {
        REG_FOCAL_X  = 3'd0,
        REG_FOCAL_Y  = 3'd1,
        REG_CENTER_X = 3'd2,
        REG_CENTER_Y = 3'd3,
        REG_K1       = 3'd4,
        REG_K2       = 3'd5,
        REG_P1       = 3'd6,
        REG_P2       = 3'd7
    } reg_idx_t;

    typedef logic signed [COEF_BITS-1:0] q_t;

    typedef struct packed {
        logic [FOCAL_BITS-1:0] focal_x;
        logic [FOCAL_BITS-1:0] focal_y;
        logic [FOCAL_BITS-1:0] center_x;
        logic [FOCAL_BITS-1:0] center_y;
        q_t                    k1;
        q_t                    k2;
        q_t                    p1;
        q_t                    p2;
    } cfg_t;

    // Saturate a wide signed value to Q4.28.
    function automatic q_t sat_q(input logic signed [71:0] v);
        q_t r;
        if (v > 72'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -72'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Product of two signed values, rounded half away from zero at bit 28.
    function automatic logic signed [71:0] mul_rnd(input logic signed [33:0] a,
                                                   input logic signed [33:0] b);
        logic        neg;
        logic [33:0] ma;
        logic [33:0] mb;
        logic [67:0] p;
        logic [71:0] m;
        logic signed [71:0] r;
        neg = a[33] ^ b[33];
        ma  = a[33] ? 34'(-a) : 34'(a);
        mb  = b[33] ? 34'(-b) : 34'(b);
        p   = ma * mb;
        m   = 72'((p + 68'(1) * (68'(1) << (Q_FRAC - 1))) >> Q_FRAC);
        r   = neg ? -$signed(m) : $signed(m);
        return r;
    endfunction

endpackage

>>> rtl/ldm_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interface with a typed payload.
// Used by every channel of the lens distortion map generator.
interface ldm_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/ldm_norm_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider: one quotient bit per stage.
// Computes round((|d| << 28) / f) with the sign of d; depends on ldm_pkg.
module ldm_norm_div #(
    parameter int TAG_BITS = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [ldm_pkg::FOCAL_BITS:0] dividend,
    input  logic [ldm_pkg::FOCAL_BITS-1:0] divisor,
    input  logic [TAG_BITS-1:0]           in_tag,
    output logic                          out_valid,
    output ldm_pkg::q_t                   quotient,
    output logic [TAG_BITS-1:0]           out_tag
);
    import ldm_pkg::*;

    // numerator = |d|*2^28 + f/2 ; width 24+28+1
    localparam int NUM_BITS = FOCAL_BITS + Q_FRAC + 1;
    localparam int STAGES   = NUM_BITS;

    logic [NUM_BITS-1:0]    num_reg  [STAGES+1];
    logic [FOCAL_BITS:0]    rem_reg  [STAGES+1];
    logic [NUM_BITS-1:0]    quo_reg  [STAGES+1];
    logic [FOCAL_BITS-1:0]  div_reg  [STAGES+1];
    logic                   neg_reg  [STAGES+1];
    logic                   vld_reg  [STAGES+1];
    logic [TAG_BITS-1:0]    tag_reg  [STAGES+1];

    logic [FOCAL_BITS-1:0]  f_eff;
    logic [FOCAL_BITS:0]    mag;

    always_comb
    begin
        f_eff = (divisor == '0) ? FOCAL_BITS'(1) : divisor;
        mag   = dividend[FOCAL_BITS] ? (FOCAL_BITS+1)'(-dividend)
                                     : (FOCAL_BITS+1)'(dividend);
    end

    // Load the first stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= (NUM_BITS'(mag) << Q_FRAC) + NUM_BITS'(f_eff >> 1);
            rem_reg[0] <= '0;
            quo_reg[0] <= '0;
            div_reg[0] <= f_eff;
            neg_reg[0] <= dividend[FOCAL_BITS];
            tag_reg[0] <= in_tag;
        end
    end

    // One quotient bit per stage, most significant first.
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [FOCAL_BITS+1:0] trial;
        logic                  fits;
        always_comb
        begin
            trial = {rem_reg[s], num_reg[s][NUM_BITS-1-s]};
            fits  = trial >= {2'b00, div_reg[s]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s+1] <= 1'b0;
            else if (en)
                vld_reg[s+1] <= vld_reg[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= fits ? (FOCAL_BITS+1)'(trial - {2'b00, div_reg[s]})
                                     : (FOCAL_BITS+1)'(trial);
                quo_reg[s+1] <= quo_reg[s] | (fits ? (NUM_BITS'(1) << (NUM_BITS-1-s))
                                                   : '0);
                num_reg[s+1] <= num_reg[s];
                div_reg[s+1] <= div_reg[s];
                neg_reg[s+1] <= neg_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    end

    // Clamp and sign.
    logic [NUM_BITS-1:0]    qm;
    logic signed [71:0]     qs;
    always_comb
    begin
        qm = quo_reg[STAGES];
        if (qm > (NUM_BITS'(1) << 32))
            qm = NUM_BITS'(1) << 32;
        qs = neg_reg[STAGES] ? -$signed(72'(qm)) : $signed(72'(qm));
    end

    assign quotient  = sat_q(qs);
    assign out_valid = vld_reg[STAGES];
    assign out_tag   = tag_reg[STAGES];

endmodule

>>> rtl/lens_distortion_map_generator.sv
`timescale 1ns / 1ps
// Lens distortion map generator: one pixel coordinate in, one remap entry out.
// Channels: in_ch (pixel_col, pixel_row), out_ch (map_col, map_row,
// saturated) and cfg_ch (index, value), all valid/ready transfers.
// Normalization runs in two one-bit-per-cycle dividers in parallel, each
// 54 register stages deep (a load stage and 53 quotient bits). The
// polynomial follows in 6 stages, then one stage scales by the focal length
// and the output register holds the clipped entry. One item enters each
// cycle; the whole pipeline advances when the output register is empty or
// taken, so throughput is one item per cycle while the receiver takes
// every cycle. When the receiver stalls with an entry in the output
// register, every stage holds and in_ch.ready drops; nothing is lost or
// repeated. Reset clears all valid bits and loads focal lengths of 1.0
// and zero for the other registers. Write configuration only while the
// block is idle. Depends on ldm_pkg and ldm_if.
module lens_distortion_map_generator #(
    parameter int COORD_BITS = ldm_pkg::COORD_BITS_DEF,
    parameter logic signed [31:0] RADIAL_K3 = ldm_pkg::RADIAL_K3_DEF
) (
    input  logic clk,
    input  logic rst_n,
    ldm_if.sink   in_ch,
    ldm_if.source out_ch,
    ldm_if.sink   cfg_ch
);
    import ldm_pkg::*;

    cfg_t cfg_reg;

    // Configuration writes.
    assign cfg_ch.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x  <= FOCAL_BITS'(256);
            cfg_reg.focal_y  <= FOCAL_BITS'(256);
            cfg_reg.center_x <= '0;
            cfg_reg.center_y <= '0;
            cfg_reg.k1       <= '0;
            cfg_reg.k2       <= '0;
            cfg_reg.p1       <= '0;
            cfg_reg.p2       <= '0;
        end
        else if (cfg_ch.valid)
        begin
            unique case (reg_idx_t'(cfg_ch.data.index))
                REG_FOCAL_X:  cfg_reg.focal_x  <= cfg_ch.data.value[FOCAL_BITS-1:0];
                REG_FOCAL_Y:  cfg_reg.focal_y  <= cfg_ch.data.value[FOCAL_BITS-1:0];
                REG_CENTER_X: cfg_reg.center_x <= cfg_ch.data.value[FOCAL_BITS-1:0];
                REG_CENTER_Y: cfg_reg.center_y <= cfg_ch.data.value[FOCAL_BITS-1:0];
                REG_K1:       cfg_reg.k1       <= cfg_ch.data.value;
                REG_K2:       cfg_reg.k2       <= cfg_ch.data.value;
                REG_P1:       cfg_reg.p1       <= cfg_ch.data.value;
                REG_P2:       cfg_reg.p2       <= cfg_ch.data.value;
                default: ;
            endcase
        end
    end

    // Global advance: the pipeline moves when the output slot is free or being taken.
    logic en;
    logic out_vld_reg;
    assign en          = !out_vld_reg || out_ch.ready;
    assign in_ch.ready = en;

    logic [COORD_BITS-1:0] col_in, row_in;
    assign col_in = in_ch.data.pixel_col[COORD_BITS-1:0];
    assign row_in = in_ch.data.pixel_row[COORD_BITS-1:0];

    logic signed [FOCAL_BITS:0] dx, dy;
    always_comb
    begin
        dx = $signed({1'b0, FOCAL_BITS'({col_in, 8'h00})}) - $signed({1'b0, cfg_reg.center_x});
        dy = $signed({1'b0, FOCAL_BITS'({row_in, 8'h00})}) - $signed({1'b0, cfg_reg.center_y});
    end

    localparam int TAG_BITS = 2 * COORD_BITS;
    logic                  dvx, dvy;
    q_t                    x0, y0;
    logic [TAG_BITS-1:0]   tag_x, tag_y;

    ldm_norm_div #(.TAG_BITS(TAG_BITS)) u_div_x (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(in_ch.valid), .dividend(dx), .divisor(cfg_reg.focal_x),
        .in_tag({col_in, row_in}),
        .out_valid(dvx), .quotient(x0), .out_tag(tag_x)
    );
    ldm_norm_div #(.TAG_BITS(TAG_BITS)) u_div_y (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(in_ch.valid), .dividend(dy), .divisor(cfg_reg.focal_y),
        .in_tag({col_in, row_in}),
        .out_valid(dvy), .quotient(y0), .out_tag(tag_y)
    );

    q_t k3;
    assign k3 = RADIAL_K3;

    // Stage 1: squares and cross product.
    logic v1_reg;
    q_t x1_reg, y1_reg, xx1_reg, yy1_reg, xy1_reg;
    logic [TAG_BITS-1:0] t1_reg;
    // Stage 2: r2.
    logic v2_reg;
    q_t x2_reg, y2_reg, xx2_reg, yy2_reg, xy2_reg, r2_2_reg;
    logic [TAG_BITS-1:0] t2_reg;
    // Stage 3: r4, tangential sums, k1*r2.
    logic v3_reg;
    q_t x3_reg, y3_reg, xy3_reg, r2_3_reg, r4_3_reg, tx3_reg, ty3_reg, a3_reg;
    logic [TAG_BITS-1:0] t3_reg;
    // Stage 4: r6, k2*r4, tangential products.
    logic v4_reg;
    q_t x4_reg, y4_reg, r6_4_reg, a4_reg, b4_reg, px_reg, py_reg, qx_reg, qy_reg;
    logic [TAG_BITS-1:0] t4_reg;
    // Stage 5: k3*r6, radial sum.
    logic v5_reg;
    q_t x5_reg, y5_reg, rad5_reg, px5_reg, py5_reg, qx5_reg, qy5_reg;
    logic [TAG_BITS-1:0] t5_reg;
    // Stage 6: corrected coordinates.
    logic v6_reg;
    q_t xc6_reg, yc6_reg;
    logic [TAG_BITS-1:0] t6_reg;
    // Stage 7: scale by focal length.
    logic v7_reg;
    logic signed [71:0] mx7_reg, my7_reg;
    logic [TAG_BITS-1:0] t7_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0; v4_reg <= 1'b0;
            v5_reg <= 1'b0; v6_reg <= 1'b0; v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= dvx; v2_reg <= v1_reg; v3_reg <= v2_reg; v4_reg <= v3_reg;
            v5_reg <= v4_reg; v6_reg <= v5_reg; v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg  <= x0;
            y1_reg  <= y0;
            xx1_reg <= sat_q(mul_rnd(34'(x0), 34'(x0)));
            yy1_reg <= sat_q(mul_rnd(34'(y0), 34'(y0)));
            xy1_reg <= sat_q(mul_rnd(34'(x0), 34'(y0)));
            t1_reg  <= tag_x;

            x2_reg   <= x1_reg;  y2_reg  <= y1_reg;
            xx2_reg  <= xx1_reg; yy2_reg <= yy1_reg; xy2_reg <= xy1_reg;
            r2_2_reg <= sat_q(72'(xx1_reg) + 72'(yy1_reg));
            t2_reg   <= t1_reg;

            x3_reg   <= x2_reg;  y3_reg <= y2_reg; xy3_reg <= xy2_reg;
            r2_3_reg <= r2_2_reg;
            r4_3_reg <= sat_q(mul_rnd(34'(r2_2_reg), 34'(r2_2_reg)));
            tx3_reg  <= sat_q(72'(r2_2_reg) + 72'(xx2_reg) + 72'(xx2_reg));
            ty3_reg  <= sat_q(72'(r2_2_reg) + 72'(yy2_reg) + 72'(yy2_reg));
            a3_reg   <= sat_q(mul_rnd(34'(cfg_reg.k1), 34'(r2_2_reg)));
            t3_reg   <= t2_reg;

            x4_reg   <= x3_reg; y4_reg <= y3_reg;
            r6_4_reg <= sat_q(mul_rnd(34'(r4_3_reg), 34'(r2_3_reg)));
            a4_reg   <= a3_reg;
            b4_reg   <= sat_q(mul_rnd(34'(cfg_reg.k2), 34'(r4_3_reg)));
            px_reg   <= sat_q(mul_rnd(34'(cfg_reg.p1), 34'(xy3_reg)));
            py_reg   <= sat_q(mul_rnd(34'(cfg_reg.p2), 34'(xy3_reg)));
            qx_reg   <= sat_q(mul_rnd(34'(cfg_reg.p2), 34'(tx3_reg)));
            qy_reg   <= sat_q(mul_rnd(34'(cfg_reg.p1), 34'(ty3_reg)));
            t4_reg   <= t3_reg;

            x5_reg   <= x4_reg; y5_reg <= y4_reg;
            rad5_reg <= sat_q(72'sd268435456 + 72'(a4_reg) + 72'(b4_reg)
                              + sat_q(mul_rnd(34'(k3), 34'(r6_4_reg))));
            px5_reg  <= px_reg; py5_reg <= py_reg;
            qx5_reg  <= qx_reg; qy5_reg <= qy_reg;
            t5_reg   <= t4_reg;

            xc6_reg <= sat_q(sat_q(mul_rnd(34'(x5_reg), 34'(rad5_reg)))
                             + 72'(px5_reg) + 72'(px5_reg) + 72'(qx5_reg));
            yc6_reg <= sat_q(sat_q(mul_rnd(34'(y5_reg), 34'(rad5_reg)))
                             + 72'(qy5_reg) + 72'(py5_reg) + 72'(py5_reg));
            t6_reg  <= t5_reg;

            mx7_reg <= mul_rnd(34'(xc6_reg), $signed({10'b0, cfg_reg.focal_x}));
            my7_reg <= mul_rnd(34'(yc6_reg), $signed({10'b0, cfg_reg.focal_y}));
            t7_reg  <= t6_reg;
        end
    end

    // Back to pixels, reflect and clip.
    logic signed [71:0] vc, vr;
    logic sc, sr;
    logic [MAP_BITS-1:0] mc, mr;
    always_comb
    begin
        vc = $signed(72'(t7_reg[TAG_BITS-1:COORD_BITS]) << 9) - mx7_reg
             - $signed(72'(cfg_reg.center_x));
        vr = $signed(72'(t7_reg[COORD_BITS-1:0]) << 9) - my7_reg
             - $signed(72'(cfg_reg.center_y));
        sc = 1'b0; sr = 1'b0;
        if (vc > 72'sd8388607)       begin mc = 24'h7fffff; sc = 1'b1; end
        else if (vc < -72'sd8388608) begin mc = 24'h800000; sc = 1'b1; end
        else                               mc = vc[MAP_BITS-1:0];
        if (vr > 72'sd8388607)       begin mr = 24'h7fffff; sr = 1'b1; end
        else if (vr < -72'sd8388608) begin mr = 24'h800000; sr = 1'b1; end
        else                               mr = vr[MAP_BITS-1:0];
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= v7_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_ch.data.map_col   <= mc;
            out_ch.data.map_row   <= mr;
            out_ch.data.saturated <= sc | sr;
        end
    end

    assign out_ch.valid = out_vld_reg;

`ifndef ASSERT_OFF
    a_div_lock: assert property (@(posedge clk) disable iff (!rst_n) dvx == dvy)
        else $error("divider lanes out of step");
    a_tag_lock: assert property (@(posedge clk) disable iff (!rst_n)
        dvx |-> tag_x == tag_y)
        else $error("divider tags differ");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("output dropped while stalled");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("input blocked with empty output");
`endif

endmodule

>>> bench/tb_lens_distortion_map_generator.sv
`timescale 1ns / 1ps
// Self-checking bench for lens_distortion_map_generator: a directed table and
// random pixels under several register settings, checked against a predictor.
// Depends on ldm_pkg, ldm_if and the block itself.
module tb_lens_distortion_map_generator;
    import ldm_pkg::*;

    typedef struct packed {
        logic [11:0] pixel_col;
        logic [11:0] pixel_row;
    } pixel_t;

    typedef struct packed {
        logic signed [MAP_BITS-1:0] map_col;
        logic signed [MAP_BITS-1:0] map_row;
        logic                       saturated;
    } remap_t;

    typedef struct packed {
        reg_idx_t              index;
        logic [COEF_BITS-1:0]  value;
    } cfg_wr_t;

    typedef struct {
        int     col;
        int     row;
        bit     fixed;
        remap_t entry;
    } pixel_row_t;

    localparam longint Q_HI      = 64'sd2147483647;
    localparam longint Q_LO      = -64'sd2147483648;
    localparam longint Q_UNIT    = 64'sd1 << 28;
    localparam longint MAP_HI    = 64'sd8388607;
    localparam longint MAP_LO    = -64'sd8388608;
    localparam int     DRAIN     = 80;
    localparam int     CYCLE_CAP = 500000;

    logic clk;
    logic rst_n;

    ldm_if #(.payload_t(pixel_t))  in_if();
    ldm_if #(.payload_t(remap_t))  out_if();
    ldm_if #(.payload_t(cfg_wr_t)) cfg_if();

    lens_distortion_map_generator u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_if),
        .out_ch (out_if),
        .cfg_ch (cfg_if)
    );

    // Shadow copy of the register file
    longint focal_x_r, focal_y_r, center_x_r, center_y_r;
    longint k1_r, k2_r, p1_r, p2_r;

    remap_t remap_pending[$];
    int     errors;
    int     cycles;
    bit     no_idle;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Clamp to the Q4.28 range
    function automatic longint clamp_q(longint v);
        if (v > Q_HI)
            return Q_HI;
        if (v < Q_LO)
            return Q_LO;
        return v;
    endfunction

    // Product scaled by 2^-28, rounded half away from zero
    function automatic longint scaled_product(longint a, longint b);
        bit                neg;
        longint unsigned   ma;
        longint unsigned   mb;
        longint unsigned   m;
        neg = (a < 0) != (b < 0);
        ma  = (a < 0) ? longint'(-a) : longint'(a);
        mb  = (b < 0) ? longint'(-b) : longint'(b);
        m   = (ma * mb + (64'd1 << 27)) >> 28;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint qmul(longint a, longint b);
        return clamp_q(scaled_product(a, b));
    endfunction

    // Pixel position relative to the center, divided by the focal length
    function automatic longint normalized(longint pix, longint ctr, longint foc);
        longint          d;
        longint unsigned f;
        longint unsigned md;
        longint unsigned m;
        d  = (pix <<< 8) - ctr;
        f  = (foc == 0) ? 64'd1 : longint'(foc);
        md = (d < 0) ? longint'(-d) : longint'(d);
        m  = ((md << 28) + (f >> 1)) / f;
        if (m > (64'd1 << 32))
            m = 64'd1 << 32;
        return clamp_q((d < 0) ? -longint'(m) : longint'(m));
    endfunction

    // Back to pixels and reflect about the input position
    function automatic longint reflected(longint pix, longint c, longint foc,
                                         longint ctr, inout bit clipped);
        longint v;
        v = (pix <<< 9) - (scaled_product(c, foc) + ctr);
        if (v > MAP_HI)
        begin
            clipped = 1'b1;
            return MAP_HI;
        end
        if (v < MAP_LO)
        begin
            clipped = 1'b1;
            return MAP_LO;
        end
        return v;
    endfunction

    function automatic remap_t predict_remap(pixel_t px);
        longint col, row, x, y, xx, yy, xy, r2, r4, r6, radial, xc, yc, mc, mr;
        bit     clipped;
        remap_t e;
        col     = px.pixel_col;
        row     = px.pixel_row;
        clipped = 1'b0;
        x       = normalized(col, center_x_r, focal_x_r);
        y       = normalized(row, center_y_r, focal_y_r);
        xx      = qmul(x, x);
        yy      = qmul(y, y);
        xy      = qmul(x, y);
        r2      = clamp_q(xx + yy);
        r4      = qmul(r2, r2);
        r6      = qmul(r4, r2);
        radial  = clamp_q(Q_UNIT + qmul(k1_r, r2) + qmul(k2_r, r4)
                          + qmul(longint'(RADIAL_K3_DEF), r6));
        xc      = clamp_q(qmul(x, radial) + 2 * qmul(p1_r, xy)
                          + qmul(p2_r, clamp_q(r2 + 2 * xx)));
        yc      = clamp_q(qmul(y, radial) + qmul(p1_r, clamp_q(r2 + 2 * yy))
                          + 2 * qmul(p2_r, xy));
        mc      = reflected(col, xc, focal_x_r, center_x_r, clipped);
        mr      = reflected(row, yc, focal_y_r, center_y_r, clipped);
        e.map_col   = mc[MAP_BITS-1:0];
        e.map_row   = mr[MAP_BITS-1:0];
        e.saturated = clipped;
        return e;
    endfunction

    // Mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Queue the prediction for every accepted pixel
    always @(posedge clk)
    begin
        if (in_if.valid && in_if.ready)
            remap_pending = {remap_pending, predict_remap(in_if.data)};
    end

    // Compare every accepted remap entry against the oldest prediction
    always @(posedge clk)
    begin
        remap_t e;
        if (out_if.valid && out_if.ready)
        begin
            if (remap_pending.size() == 0)
            begin
                $error("unexpected remap entry %h", out_if.data);
                errors++;
            end
            else
            begin
                e = remap_pending.pop_front();
                if (out_if.data.map_col !== e.map_col)
                begin
                    $error("map_col expected %0d got %0d", e.map_col, out_if.data.map_col);
                    errors++;
                end
                if (out_if.data.map_row !== e.map_row)
                begin
                    $error("map_row expected %0d got %0d", e.map_row, out_if.data.map_row);
                    errors++;
                end
                if (out_if.data.saturated !== e.saturated)
                begin
                    $error("saturated expected %0d got %0d", e.saturated,
                           out_if.data.saturated);
                    errors++;
                end
            end
        end
    end

    // Stall the receiver at random
    always @(posedge clk)
    begin
        int hold;
        if (!rst_n)
            out_if.ready <= 1'b1;
        else if (hold > 0)
        begin
            hold--;
            out_if.ready <= 1'b0;
        end
        else
        begin
            hold = idle_len();
            out_if.ready <= (hold == 0);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("tb_lens_distortion_map_generator: FAIL");
            $finish;
        end
    end

    task automatic push_pixel(int col, int row);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid          <= 1'b1;
        in_if.data.pixel_col <= col[11:0];
        in_if.data.pixel_row <= row[11:0];
        do @(posedge clk); while (!in_if.ready);
    endtask

    task automatic end_stream();
        in_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] v);
        cfg_if.valid       <= 1'b1;
        cfg_if.data.index  <= idx;
        cfg_if.data.value  <= v;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
        case (idx)
            REG_FOCAL_X:  focal_x_r  = v[23:0];
            REG_FOCAL_Y:  focal_y_r  = v[23:0];
            REG_CENTER_X: center_x_r = v[23:0];
            REG_CENTER_Y: center_y_r = v[23:0];
            REG_K1:       k1_r = longint'($signed(v));
            REG_K2:       k2_r = longint'($signed(v));
            REG_P1:       p1_r = longint'($signed(v));
            REG_P2:       p2_r = longint'($signed(v));
            default:      ;
        endcase
    endtask

    // Let the pipeline empty before touching the registers
    task automatic drain();
        while (remap_pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic write_all(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
                             logic [31:0] cy, logic [31:0] k1, logic [31:0] k2,
                             logic [31:0] p1, logic [31:0] p2);
        write_reg(REG_FOCAL_X, fx);
        write_reg(REG_FOCAL_Y, fy);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_K1, k1);
        write_reg(REG_K2, k2);
        write_reg(REG_P1, p1);
        write_reg(REG_P2, p2);
    endtask

    function automatic logic [31:0] signed_upto(int unsigned mag);
        int v;
        v = int'($urandom_range(0, mag));
        return ($urandom_range(0, 1) != 0) ? -v : v;
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return 4095;
            default: return $urandom_range(0, 4095);
        endcase
    endfunction

    pixel_row_t directed[$];

    initial
    begin
        errors = 0;
        cycles = 0;
        no_idle = 1'b0;
        focal_x_r = 256;
        focal_y_r = 256;
        center_x_r = 0;
        center_y_r = 0;
        k1_r = 0;
        k2_r = 0;
        p1_r = 0;
        p2_r = 0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        cfg_if.valid = 1'b0;
        cfg_if.data = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: unit focal length, zero center, no distortion
        directed = '{
            '{0,    0,    1'b1, '{24'sd0,       24'sd0,       1'b0}},
            '{1,    7,    1'b1, '{24'sd256,     24'sd1792,    1'b0}},
            '{4095, 4095, 1'b1, '{24'sd2094592, 24'sd2094592, 1'b0}},
            '{4095, 0,    1'b0, '{24'sd0,       24'sd0,       1'b0}},
            '{0,    4095, 1'b0, '{24'sd0,       24'sd0,       1'b0}},
            '{8,    8,    1'b0, '{24'sd0,       24'sd0,       1'b0}},
            '{2048, 2048, 1'b0, '{24'sd0,       24'sd0,       1'b0}},
            '{2730, 1365, 1'b0, '{24'sd0,       24'sd0,       1'b0}},
            '{1365, 2730, 1'b0, '{24'sd0,       24'sd0,       1'b0}}
        };
        foreach (directed[i])
        begin
            pixel_t px;
            px.pixel_col = directed[i].col[11:0];
            px.pixel_row = directed[i].row[11:0];
            if (directed[i].fixed && predict_remap(px) !== directed[i].entry)
            begin
                $error("table row %0d disagrees with predictor", i);
                errors++;
            end
            push_pixel(directed[i].col, directed[i].row);
        end
        end_stream();

        // Walk through extreme and random register settings
        for (int ph = 1; ph <= 11; ph++)
        begin
            int n;
            drain();
            no_idle = (ph % 4 == 0);
            case (ph)
                1: write_all(0, 0, 0, 0, 32'h80000000, 32'h80000000,
                             32'h80000000, 32'h80000000);
                2: write_all(32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF, 32'hFFFFFF,
                             32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
                3: write_all(1, 32'hFFFFFF, 32'hFFFFFF, 0, 0, 0, 0, 0);
                5, 9: write_all($urandom_range(0, 32'hFFFFFF), $urandom_range(0, 32'hFFFFFF),
                             $urandom_range(0, 32'hFFFFFF), $urandom_range(0, 32'hFFFFFF),
                             $urandom, $urandom, $urandom, $urandom);
                default: write_all($urandom_range(32'h1000, 32'h100000),
                             $urandom_range(32'h1000, 32'h100000),
                             $urandom_range(0, 4095 * 256), $urandom_range(0, 4095 * 256),
                             signed_upto(32'h10000000), signed_upto(32'h08000000),
                             signed_upto(32'h01000000), signed_upto(32'h01000000));
            endcase
            n = (ph <= 3) ? 30 : 105;
            if (ph <= 3)
            begin
                push_pixel(0, 0);
                push_pixel(4095, 4095);
                push_pixel(0, 4095);
                push_pixel(4095, 0);
            end
            repeat (n) push_pixel(rand_coord(), rand_coord());
            end_stream();
        end

        drain();
        if (errors == 0)
            $display("tb_lens_distortion_map_generator: PASS");
        else
            $display("tb_lens_distortion_map_generator: FAIL");
        $finish;
    end
endmodule

>>> sim.f
rtl/ldm_pkg.sv
rtl/ldm_if.sv
rtl/ldm_norm_div.sv
rtl/lens_distortion_map_generator.sv
bench/tb_lens_distortion_map_generator.sv
